>>> rtl/core/i2cmts_pkg.sv
package i2cmts_pkg;

  // Commands carried by an input item.
  typedef enum logic [1:0] {
    CMD_LOAD_DESC = 2'd0,
    CMD_LOAD_BYTE = 2'd1,
    CMD_START     = 2'd2,
    CMD_EVENT     = 2'd3
  } cmd_e;

  // Destination of a result.
  typedef enum logic [1:0] {
    TGT_CTRL   = 2'd0,
    TGT_TXDATA = 2'd1,
    TGT_STATUS = 2'd2,
    TGT_RXBYTE = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_RD_CUR,
    SEQ_RD_NXT,
    SEQ_CALC,
    SEQ_EMIT
  } seq_state_e;

  // Controller control register bits.
  localparam logic [7:0] CR_MSS  = 8'h80;
  localparam logic [7:0] CR_SCC  = 8'h40;
  localparam logic [7:0] CR_ACKE = 8'h20;
  localparam logic [7:0] CR_WSEL = 8'h10;
  localparam logic [7:0] CR_CNDE = 8'h08;
  localparam logic [7:0] CR_INTE = 8'h04;
  localparam logic [7:0] CR_BER  = 8'h02;
  localparam logic [7:0] CR_INT  = 8'h01;

  // Controller bus status bits.
  localparam logic [7:0] SR_FBT  = 8'h80;
  localparam logic [7:0] SR_RACK = 8'h40;
  localparam logic [7:0] SR_RSA  = 8'h20;
  localparam logic [7:0] SR_TRX  = 8'h10;
  localparam logic [7:0] SR_SPC  = 8'h02;

  // Composite control values written by the sequencer.
  localparam logic [7:0] CTRL_STOP      = CR_ACKE;
  localparam logic [7:0] CTRL_START     = CR_MSS | CR_INTE | CR_INT;
  localparam logic [7:0] CTRL_TX_NEXT   = CR_MSS | CR_INTE;
  localparam logic [7:0] CTRL_TX_RESTART = CR_MSS | CR_SCC | CR_INTE | CR_INT;
  localparam logic [7:0] CTRL_RX_NEXT   = CR_MSS | CR_ACKE | CR_WSEL | CR_INTE;
  localparam logic [7:0] CTRL_RX_RESTART = CR_MSS | CR_SCC | CR_ACKE | CR_INTE | CR_INT;

  typedef struct packed {
    target_e     target;
    logic [7:0]  value;
    logic [1:0]  msg;
    logic [4:0]  index;
  } result_t;

  function automatic result_t mk_write(target_e target, logic [7:0] value);
    result_t r;
    r.target = target;
    r.value  = value;
    r.msg    = 2'd0;
    r.index  = 5'd0;
    return r;
  endfunction

endpackage

>>> rtl/core/i2cmts_if.sv
interface i2cmts_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] msg_slot;
  logic [4:0] byte_index;
  logic [6:0] target_address;
  logic       read_flag;
  logic [5:0] msg_length;
  logic [7:0] data_byte;
  logic [2:0] msg_count;
  logic [7:0] ctrl_status;
  logic [7:0] bus_status;

  modport source (
    output valid, command, msg_slot, byte_index, target_address, read_flag,
           msg_length, data_byte, msg_count, ctrl_status, bus_status,
    input  ready
  );
  modport sink (
    input  valid, command, msg_slot, byte_index, target_address, read_flag,
           msg_length, data_byte, msg_count, ctrl_status, bus_status,
    output ready
  );
endinterface

interface i2cmts_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_target;
  logic [7:0] reg_value;
  logic [1:0] rx_msg;
  logic [4:0] rx_index;
  logic [1:0] xfer_status;
  logic       last;

  modport source (
    output valid, reg_target, reg_value, rx_msg, rx_index, xfer_status, last,
    input  ready
  );
  modport sink (
    input  valid, reg_target, reg_value, rx_msg, rx_index, xfer_status, last,
    output ready
  );
endinterface

>>> rtl/core/i2c_master_transfer_sequencer_top.sv
// I2C master transfer sequencer. Software loads up to MAX_MESSAGES message
// descriptors (seven-bit address, read flag, length) and the bytes to send, then
// issues a start item; from then on every controller event item (captured control
// and bus status bytes plus the received data byte) is answered with one to four
// results, each a register write for the byte-level controller or a received byte,
// the final one flagged by last and all carrying the transfer status after the item.
// Load items give no result, as does an event while no transfer is running. A start
// or event item passes through acceptance, two reads of the descriptor memory's
// read port for the current and following message, evaluation, and then one
// result transfer per result. Descriptors and send bytes live in two synchronous
// memories with no reset; reading an entry never loaded is undefined. A new item
// is taken only once every result of the previous one has been transferred.
module i2c_master_transfer_sequencer_top
  import i2cmts_pkg::*;
#(
  parameter int MAX_MESSAGES = 4,
  parameter int MAX_MSG_LEN  = 32
) (
  input  logic            clk,
  input  logic            rst,
  i2cmts_item_if.sink     item,
  i2cmts_result_if.source result
);

  localparam int SLOT_W      = $clog2(MAX_MESSAGES > 1 ? MAX_MESSAGES : 2);
  localparam int LEN_W       = $clog2(MAX_MSG_LEN + 1);
  localparam int LEFT_W      = $clog2(MAX_MESSAGES + 1);
  localparam int STORE_DEPTH = MAX_MESSAGES * MAX_MSG_LEN;
  localparam int STORE_AW    = $clog2(STORE_DEPTH > 1 ? STORE_DEPTH : 2);
  localparam int DESC_W      = 8 + LEN_W;

  typedef struct packed {
    logic [6:0]       addr;
    logic             rd;
    logic [LEN_W-1:0] len;
  } desc_t;

  // Sequencer state.
  seq_state_e        state;
  seq_state_e        state_next;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] cur_slot_next;
  logic [LEFT_W-1:0] msgs_left;
  logic [LEFT_W-1:0] msgs_left_next;
  logic [LEN_W-1:0]  byte_pos;
  logic [LEN_W-1:0]  byte_pos_next;
  status_e           xfer_state;
  status_e           xfer_state_next;

  // Captured item payload.
  cmd_e              cmd;
  logic [7:0]        data;
  logic [7:0]        ctrl;
  logic [7:0]        bstat;
  logic [2:0]        count;

  // Memory ports.
  logic                table_we;
  logic [SLOT_W-1:0]   table_waddr;
  desc_t               table_wdata;
  logic [SLOT_W-1:0]   table_raddr;
  logic [DESC_W-1:0]   table_rdata;
  logic                store_we;
  logic [STORE_AW-1:0] store_waddr;
  logic [STORE_AW-1:0] store_raddr;
  logic [7:0]          store_rdata;

  desc_t             desc_cur;
  desc_t             desc_nxt;

  // Result buffer.
  result_t           res_buf [4];
  result_t           res_next [4];
  logic [2:0]        res_cnt;
  logic [2:0]        res_cnt_next;
  logic [1:0]        out_ptr;

  logic              item_acc;
  logic              result_acc;
  logic              out_last;
  logic              slot_ok;
  logic              event_live;

  assign item_acc   = item.valid && item.ready;
  assign result_acc = result.valid && result.ready;
  assign out_last   = ({1'b0, out_ptr} + 3'd1) == res_cnt;
  assign slot_ok    = int'(item.msg_slot) < MAX_MESSAGES;
  assign event_live = xfer_state == ST_BUSY;
  assign desc_nxt   = desc_t'(table_rdata);

  // Loads are written straight into the memories on the accepting edge.
  always_comb begin
    table_we          = item_acc && (item.command == CMD_LOAD_DESC) && slot_ok;
    table_waddr       = SLOT_W'(item.msg_slot);
    table_wdata.addr  = item.target_address;
    table_wdata.rd    = item.read_flag;
    table_wdata.len   = (int'(item.msg_length) > MAX_MSG_LEN) ?
                        LEN_W'(MAX_MSG_LEN) : LEN_W'(item.msg_length);
    store_we          = item_acc && (item.command == CMD_LOAD_BYTE) && slot_ok &&
                        (int'(item.byte_index) < MAX_MSG_LEN);
    store_waddr       = STORE_AW'(int'(item.msg_slot) * MAX_MSG_LEN +
                                  int'(item.byte_index));
  end

  i2cmts_ram #(
    .WIDTH (DESC_W),
    .DEPTH (MAX_MESSAGES)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (table_waddr),
    .wdata (table_wdata),
    .raddr (table_raddr),
    .rdata (table_rdata)
  );

  i2cmts_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (item.data_byte),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (item_acc && ((item.command == CMD_START) ||
                         ((item.command == CMD_EVENT) && event_live))) begin
          state_next = SEQ_RD_CUR;
        end
      end
      SEQ_RD_CUR: state_next = SEQ_RD_NXT;
      SEQ_RD_NXT: state_next = SEQ_CALC;
      SEQ_CALC:   state_next = SEQ_EMIT;
      SEQ_EMIT: begin
        if (result_acc && out_last) begin
          state_next = SEQ_IDLE;
        end
      end
      default:    state_next = SEQ_IDLE;
    endcase
  end

  // Outputs and memory read addresses.
  always_comb begin
    item.ready   = 1'b0;
    result.valid = 1'b0;
    table_raddr  = cur_slot;
    store_raddr  = '0;
    unique case (state)
      SEQ_IDLE:   item.ready = 1'b1;
      SEQ_RD_CUR: begin
        // A start always begins with the first message.
        table_raddr = (cmd == CMD_START) ? '0 : cur_slot;
        store_raddr = (int'(byte_pos) < MAX_MSG_LEN) ?
                      STORE_AW'(int'(cur_slot) * MAX_MSG_LEN + int'(byte_pos)) : '0;
      end
      SEQ_RD_NXT: begin
        table_raddr = (int'(cur_slot) + 1 < MAX_MESSAGES) ?
                      SLOT_W'(int'(cur_slot) + 1) : '0;
        // The send byte stays addressed so that it is still on the read port at
        // evaluation.
        store_raddr = (int'(byte_pos) < MAX_MSG_LEN) ?
                      STORE_AW'(int'(cur_slot) * MAX_MSG_LEN + int'(byte_pos)) : '0;
      end
      SEQ_CALC:   ;
      SEQ_EMIT:   result.valid = 1'b1;
      default:    ;
    endcase
  end

  assign result.reg_target  = res_buf[out_ptr].target;
  assign result.reg_value   = res_buf[out_ptr].value;
  assign result.rx_msg      = res_buf[out_ptr].msg;
  assign result.rx_index    = res_buf[out_ptr].index;
  assign result.xfer_status = xfer_state;
  assign result.last        = out_last;

  // Evaluation of a start or event. Results are appended in order; a message that
  // has run out of bytes either moves to the next message with a repeated start
  // or ends the transfer with a stop.
  always_comb begin
    logic [2:0]        k;
    logic              finish;
    logic [7:0]        restart_ctrl;
    logic [LEFT_W-1:0] left_dec;
    logic [LEN_W-1:0]  pos_rx;

    k               = 3'd0;
    finish          = 1'b0;
    restart_ctrl    = CTRL_TX_RESTART;
    left_dec        = msgs_left;
    pos_rx          = byte_pos;
    for (int i = 0; i < 4; i++) begin
      res_next[i] = mk_write(TGT_CTRL, 8'h00);
    end
    cur_slot_next   = cur_slot;
    msgs_left_next  = msgs_left;
    byte_pos_next   = byte_pos;
    xfer_state_next = xfer_state;

    if (cmd == CMD_START) begin
      cur_slot_next   = '0;
      byte_pos_next   = '0;
      xfer_state_next = ST_BUSY;
      if (count == 3'd0) begin
        msgs_left_next = LEFT_W'(1);
      end else if (int'(count) > MAX_MESSAGES) begin
        msgs_left_next = LEFT_W'(MAX_MESSAGES);
      end else begin
        msgs_left_next = LEFT_W'(count);
      end
      res_next[0] = mk_write(TGT_CTRL, 8'h00);
      res_next[1] = mk_write(TGT_TXDATA, {desc_cur.addr, desc_cur.rd});
      res_next[2] = mk_write(TGT_CTRL, CTRL_START);
      k = 3'd3;
    end else begin
      priority if (((ctrl & CR_BER) != 8'h00) || ((ctrl & CR_SCC) == 8'h00) ||
                   ((ctrl & CR_MSS) == 8'h00) || ((bstat & SR_RSA) != 8'h00)) begin
        // Abort: bus error, lost arbitration, slave mode or reserved address.
        xfer_state_next = ST_ERR;
        res_next[0] = mk_write(TGT_CTRL, ctrl & ~CR_INT);
        res_next[1] = mk_write(TGT_CTRL, CTRL_STOP);
        k = 3'd2;
      end else if ((bstat & SR_RACK) != 8'h00) begin
        xfer_state_next = ST_ERR;
        res_next[0] = mk_write(TGT_CTRL, CTRL_STOP);
        k = 3'd1;
      end else if ((bstat & SR_SPC) != 8'h00) begin
        xfer_state_next = ST_OK;
        res_next[0] = mk_write(TGT_STATUS, bstat & ~SR_SPC);
        res_next[1] = mk_write(TGT_CTRL, ctrl & ~(CR_CNDE | CR_SCC));
        res_next[2] = mk_write(TGT_CTRL, CTRL_STOP);
        k = 3'd3;
      end else if ((bstat & SR_TRX) != 8'h00) begin
        if (byte_pos < desc_cur.len) begin
          byte_pos_next = byte_pos + LEN_W'(1);
          res_next[0] = mk_write(TGT_TXDATA, store_rdata);
          res_next[1] = mk_write(TGT_CTRL, CTRL_TX_NEXT);
          k = 3'd2;
        end else begin
          finish       = 1'b1;
          restart_ctrl = CTRL_TX_RESTART;
        end
      end else begin
        // Receive step.
        if (((bstat & SR_FBT) == 8'h00) && (byte_pos < desc_cur.len)) begin
          res_next[0].target = TGT_RXBYTE;
          res_next[0].value  = data;
          res_next[0].msg    = 2'(cur_slot);
          res_next[0].index  = 5'(byte_pos);
          pos_rx = byte_pos + LEN_W'(1);
          k = 3'd1;
        end
        byte_pos_next = pos_rx;
        if (pos_rx < desc_cur.len) begin
          res_next[k[1:0]] = mk_write(TGT_CTRL, CTRL_RX_NEXT);
          k = k + 3'd1;
        end else begin
          // Last byte is NACKed.
          res_next[k[1:0]] = mk_write(TGT_CTRL,
                                      (ctrl & ~(CR_ACKE | CR_INTE | CR_INT)) | CR_WSEL);
          k = k + 3'd1;
          finish       = 1'b1;
          restart_ctrl = CTRL_RX_RESTART;
        end
      end

      if (finish) begin
        if (msgs_left != '0) begin
          left_dec = msgs_left - LEFT_W'(1);
        end
        msgs_left_next = left_dec;
        if (left_dec == '0) begin
          xfer_state_next  = ST_OK;
          res_next[k[1:0]] = mk_write(TGT_CTRL, CTRL_STOP);
          k = k + 3'd1;
        end else begin
          cur_slot_next    = cur_slot + SLOT_W'(1);
          byte_pos_next    = '0;
          res_next[k[1:0]] = mk_write(TGT_TXDATA, {desc_nxt.addr, desc_nxt.rd});
          k = k + 3'd1;
          res_next[k[1:0]] = mk_write(TGT_CTRL, restart_ctrl);
          k = k + 3'd1;
        end
      end
    end
    res_cnt_next = k;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      cur_slot   <= '0;
      msgs_left  <= '0;
      byte_pos   <= '0;
      xfer_state <= ST_OK;
      out_ptr    <= 2'd0;
      res_cnt    <= 3'd0;
    end else begin
      state <= state_next;
      if (state == SEQ_CALC) begin
        cur_slot   <= cur_slot_next;
        msgs_left  <= msgs_left_next;
        byte_pos   <= byte_pos_next;
        xfer_state <= xfer_state_next;
        res_cnt    <= res_cnt_next;
        out_ptr    <= 2'd0;
      end else if (result_acc) begin
        out_ptr <= out_ptr + 2'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      cmd   <= cmd_e'(item.command);
      data  <= item.data_byte;
      ctrl  <= item.ctrl_status;
      bstat <= item.bus_status;
      count <= item.msg_count;
    end
    if (state == SEQ_RD_NXT) begin
      desc_cur <= desc_t'(table_rdata);
    end
    if (state == SEQ_CALC) begin
      for (int i = 0; i < 4; i++) begin
        res_buf[i] <= res_next[i];
      end
    end
  end

  // The block never takes an item while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item.ready && result.valid))
    else $error("item accepted while results pending");

  // Once the last result is transferred the block is ready for the next item.
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.last) |=> item.ready)
    else $error("not ready after final result");

  // A running transfer always has a message outstanding.
  a_busy_has_msgs: assert property (@(posedge clk) disable iff (rst)
    (xfer_state == ST_BUSY) |-> (msgs_left != '0))
    else $error("busy with no message left");

  // The current message stays within the descriptor table.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    int'(cur_slot) < MAX_MESSAGES)
    else $error("current message out of range");

  // Every evaluation produces between one and four results.
  a_res_count: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_EMIT) |-> ((res_cnt != 3'd0) && (res_cnt <= 3'd4)))
    else $error("bad result count");

endmodule

>>> rtl/core/i2cmts_ram.sv
module i2cmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
